@@ rtl/core/ufss_pkg.sv @@
// ufss_pkg: shared types and constants of the union-find spanning selector.
// Used by the top level, the port checker and the testbench. No dependencies.
`timescale 1ns / 1ps

package ufss_pkg;

  localparam int NODE_W        = 11;
  localparam int COST_W        = 52;
  localparam int SUM_W         = 63;
  localparam int RANK_W        = 4;
  localparam int NODES_DEFAULT = 2048;

  localparam logic [RANK_W-1:0] RANK_MAX = '1;
  localparam logic [SUM_W-1:0]  SUM_MAX  = '1;

  typedef struct packed {
    logic [NODE_W-1:0] node_a;
    logic [NODE_W-1:0] node_b;
    logic [COST_W-1:0] offer_cost;
  } in_t;

  typedef struct packed {
    logic             accepted;
    logic             station_offer;
    logic [SUM_W-1:0] total_cost;
  } out_t;

  // per-node set data, meaningful at a root only
  typedef struct packed {
    logic              powered;
    logic [RANK_W-1:0] rank;
  } meta_t;

endpackage

@@ rtl/core/ufss_ram.sv @@
// ufss_ram: single-write, single-read synchronous RAM with a registered read port,
// with write-to-read forwarding on a same-address collision. Uses no package.
`timescale 1ns / 1ps

module ufss_ram #(
  parameter int DEPTH = 2048,
  parameter int WIDTH = 11
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;
  logic [WIDTH-1:0] fwd_data_q;
  logic             fwd_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q    <= mem[raddr_i];
    fwd_data_q <= wdata_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_q <= 1'b0;
    end else begin
      fwd_q <= we_i && (waddr_i == raddr_i);
    end
  end

  assign rdata_o = fwd_q ? fwd_data_q : rdata_q;

endmodule

@@ rtl/core/union_find_spanning_selector_unit.sv @@
// union_find_spanning_selector_unit: Kruskal acceptance engine over a
// disjoint-set store. Depends on ufss_pkg and ufss_ram.
`timescale 1ns / 1ps

// Channel  | Dir | Handshake                | Payload
// ---------+-----+--------------------------+---------------------------------
// in       | in  | in_valid_i / in_ready_o  | in_data_i  (node_a, node_b, cost)
// out      | out | out_valid_o / out_ready_i| out_data_o (accepted, station,
//          |     |                          |             total_cost)
//
// Sequence: one offer at a time. A root find walks the parent RAM, one read per
//   link, and path compression walks the path again; a link offer does two
//   finds. Around them: the accept, one meta read per root, decision and
//   result load.
// Reset: a clearing pass writes parent[i]=i and zero meta to every entry;
//   in_ready_o stays low until it ends.
// Stalls: the result register holds one transfer; the next offer is taken while
//   it waits, and that offer's result waits in S_PUSH until the slot frees.

module union_find_spanning_selector_unit #(
  parameter int NODES = ufss_pkg::NODES_DEFAULT
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  ufss_pkg::in_t in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output ufss_pkg::out_t out_data_o
);

  import ufss_pkg::*;

  localparam int IDX_W  = $clog2(NODES);
  localparam int META_W = $bits(meta_t);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NODES - 1);

  localparam logic [2:0] S_CLEAR  = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_FIND   = 3'd2;  // walk parent links to the root
  localparam logic [2:0] S_COMP   = 3'd3;  // second walk, point path at root
  localparam logic [2:0] S_META_A = 3'd4;
  localparam logic [2:0] S_META_B = 3'd5;
  localparam logic [2:0] S_DECIDE = 3'd6;
  localparam logic [2:0] S_PUSH   = 3'd7;

  logic [2:0]       state_q, state_d;
  logic [IDX_W-1:0] clr_q, clr_d;
  logic [IDX_W-1:0] cur_q, cur_d;      // walk position
  logic [IDX_W-1:0] origin_q, origin_d;// node whose root is being found
  logic [IDX_W-1:0] root_q, root_d;    // last root found (rb for a link)
  logic [IDX_W-1:0] ra_q, ra_d;
  logic [IDX_W-1:0] b_idx_q, b_idx_d;
  logic             phase_b_q, phase_b_d;
  logic             station_q, station_d;
  logic [COST_W-1:0] cost_q, cost_d;
  meta_t            meta_a_q, meta_a_d;
  meta_t            meta_b_q, meta_b_d;
  logic [SUM_W-1:0] sum_q, sum_d;
  out_t             res_q, res_d;
  out_t             out_q, out_d;
  logic             out_valid_q, out_valid_d;

  // RAM ports
  logic             par_we;
  logic [IDX_W-1:0] par_waddr, par_wdata, par_raddr, par_rdata;
  logic             meta_we;
  logic [IDX_W-1:0] meta_waddr, meta_raddr;
  meta_t            meta_wdata, meta_rdata;

  // end of a root find
  logic             fin;
  logic [IDX_W-1:0] fin_root;

  // offer decode
  logic             a_ok, b_ok;
  logic [IDX_W-1:0] a_idx;

  // decision
  logic             take;
  logic [SUM_W:0]   sum_ext;

  ufss_ram #(.DEPTH(NODES), .WIDTH(IDX_W)) u_parent (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (par_we),
    .waddr_i (par_waddr),
    .wdata_i (par_wdata),
    .raddr_i (par_raddr),
    .rdata_o (par_rdata)
  );

  ufss_ram #(.DEPTH(NODES), .WIDTH(META_W)) u_meta (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (meta_we),
    .waddr_i (meta_waddr),
    .wdata_i (meta_wdata),
    .raddr_i (meta_raddr),
    .rdata_o (meta_rdata)
  );

  assign a_ok  = 32'(in_data_i.node_a) < 32'(NODES);
  assign b_ok  = 32'(in_data_i.node_b) < 32'(NODES);
  assign a_idx = IDX_W'(in_data_i.node_a);

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // saturating add: sum < 2^63, cost < 2^52, so carry out means overflow
  assign sum_ext = {1'b0, sum_q} + (SUM_W+1)'(cost_q);

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    cur_d       = cur_q;
    origin_d    = origin_q;
    root_d      = root_q;
    ra_d        = ra_q;
    b_idx_d     = b_idx_q;
    phase_b_d   = phase_b_q;
    station_d   = station_q;
    cost_d      = cost_q;
    meta_a_d    = meta_a_q;
    meta_b_d    = meta_b_q;
    sum_d       = sum_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;

    par_we      = 1'b0;
    par_waddr   = cur_q;
    par_wdata   = root_q;
    par_raddr   = cur_q;
    meta_we     = 1'b0;
    meta_waddr  = ra_q;
    meta_wdata  = meta_a_q;
    meta_raddr  = root_q;

    fin      = 1'b0;
    fin_root = cur_q;
    take     = 1'b0;

    unique case (state_q)
      S_CLEAR: begin
        par_we     = 1'b1;
        par_waddr  = clr_q;
        par_wdata  = clr_q;
        meta_we    = 1'b1;
        meta_waddr = clr_q;
        meta_wdata = '0;
        clr_d      = clr_q + IDX_W'(1);
        if (clr_q == LAST_IDX) begin
          state_d = S_IDLE;
        end
      end

      S_IDLE: begin
        if (in_valid_i) begin
          station_d = (in_data_i.node_a == in_data_i.node_b);
          cost_d    = in_data_i.offer_cost;
          b_idx_d   = IDX_W'(in_data_i.node_b);
          if (a_ok && b_ok) begin
            cur_d     = a_idx;
            origin_d  = a_idx;
            phase_b_d = 1'b0;
            par_raddr = a_idx;
            state_d   = S_FIND;
          end else begin
            // out of range: rejected, state untouched
            res_d.accepted      = 1'b0;
            res_d.station_offer = (in_data_i.node_a == in_data_i.node_b);
            res_d.total_cost    = sum_q;
            state_d             = S_PUSH;
          end
        end
      end

      S_FIND: begin
        if (par_rdata == cur_q) begin
          if (cur_q == origin_q) begin
            fin      = 1'b1;
            fin_root = cur_q;
          end else begin
            root_d    = cur_q;
            cur_d     = origin_q;
            par_raddr = origin_q;
            state_d   = S_COMP;
          end
        end else begin
          cur_d     = par_rdata;
          par_raddr = par_rdata;
        end
      end

      S_COMP: begin
        par_we    = 1'b1;
        par_waddr = cur_q;
        par_wdata = root_q;
        if (par_rdata == root_q) begin
          fin      = 1'b1;
          fin_root = root_q;
        end else begin
          cur_d     = par_rdata;
          par_raddr = par_rdata;
        end
      end

      S_META_A: begin
        meta_a_d   = meta_rdata;
        meta_raddr = root_q;
        state_d    = station_q ? S_DECIDE : S_META_B;
      end

      S_META_B: begin
        meta_b_d = meta_rdata;
        state_d  = S_DECIDE;
      end

      S_DECIDE: begin
        if (station_q) begin
          take       = !meta_a_q.powered;
          meta_we    = take;
          meta_waddr = ra_q;
          meta_wdata = '{powered: 1'b1, rank: meta_a_q.rank};
        end else begin
          take = (ra_q != root_q) && !(meta_a_q.powered && meta_b_q.powered);
          par_we  = take;
          meta_we = take;
          meta_wdata.powered = meta_a_q.powered || meta_b_q.powered;
          if (meta_a_q.rank > meta_b_q.rank) begin
            par_waddr       = root_q;
            par_wdata       = ra_q;
            meta_waddr      = ra_q;
            meta_wdata.rank = meta_a_q.rank;
          end else begin
            par_waddr       = ra_q;
            par_wdata       = root_q;
            meta_waddr      = root_q;
            meta_wdata.rank = meta_b_q.rank;
            if (meta_a_q.rank == meta_b_q.rank && meta_b_q.rank != RANK_MAX) begin
              meta_wdata.rank = meta_b_q.rank + RANK_W'(1);
            end
          end
        end
        if (take) begin
          sum_d = sum_ext[SUM_W] ? SUM_MAX : sum_ext[SUM_W-1:0];
        end
        res_d.accepted      = take;
        res_d.station_offer = station_q;
        res_d.total_cost    = take ? (sum_ext[SUM_W] ? SUM_MAX : sum_ext[SUM_W-1:0])
                                   : sum_q;
        state_d = S_PUSH;
      end

      S_PUSH: begin
        if (!out_valid_q || out_ready_i) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
    endcase

    if (fin) begin
      root_d = fin_root;
      if (!phase_b_q && !station_q) begin
        // root of a found; go find b
        ra_d      = fin_root;
        cur_d     = b_idx_q;
        origin_d  = b_idx_q;
        phase_b_d = 1'b1;
        par_raddr = b_idx_q;
        state_d   = S_FIND;
      end else begin
        if (!phase_b_q) begin
          ra_d = fin_root;
        end
        meta_raddr = phase_b_q ? ra_q : fin_root;
        state_d    = S_META_A;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
      sum_q       <= '0;
      phase_b_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
      sum_q       <= sum_d;
      phase_b_q   <= phase_b_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q     <= cur_d;
    origin_q  <= origin_d;
    root_q    <= root_d;
    ra_q      <= ra_d;
    b_idx_q   <= b_idx_d;
    station_q <= station_d;
    cost_q    <= cost_d;
    meta_a_q  <= meta_a_d;
    meta_b_q  <= meta_b_d;
    res_q     <= res_d;
    out_q     <= out_d;
  end

endmodule

@@ rtl/core/ufss_checker.sv @@
// ufss_checker: port-level assertions for union_find_spanning_selector_unit,
// attached by bind. Depends on ufss_pkg.
`timescale 1ns / 1ps

module ufss_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           in_valid_i,
  input logic           in_ready_o,
  input logic           out_valid_o,
  input logic           out_ready_i,
  input ufss_pkg::out_t out_data_o
);

  import ufss_pkg::*;

  logic             in_xfer, out_xfer;
  logic [1:0]       pend_q;      // offers taken whose result is not yet transferred
  logic [SUM_W-1:0] last_total_q;

  assign in_xfer  = in_valid_i && in_ready_o;
  assign out_xfer = out_valid_o && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q       <= '0;
      last_total_q <= '0;
    end else begin
      pend_q <= pend_q + 2'(in_xfer) - 2'(out_xfer);
      if (out_xfer) begin
        last_total_q <= out_data_o.total_cost;
      end
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed or dropped while stalled");

  a_no_orphan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q == 2'd0 |-> !out_valid_o)
    else $error("result without a pending offer");

  a_pend_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q != 2'd3 && !(pend_q == 2'd2 && in_xfer))
    else $error("more than two offers in flight");

  a_reject_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_xfer && !out_data_o.accepted |-> out_data_o.total_cost == last_total_q)
    else $error("rejected offer changed the total");

  a_accept_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_xfer && out_data_o.accepted |-> out_data_o.total_cost >= last_total_q)
    else $error("total decreased");

endmodule

bind union_find_spanning_selector_unit ufss_checker u_ufss_checker (.*);

@@ test/tb_union_find_spanning_selector_unit.sv @@
`timescale 1ns / 1ps
// tb_union_find_spanning_selector_unit: self-checking bench for the spanning selector.
// Depends on ufss_pkg and union_find_spanning_selector_unit; reads no files.

module tb_union_find_spanning_selector_unit;
  import ufss_pkg::*;

  localparam int NODES         = NODES_DEFAULT;
  localparam int RANDOM_OFFERS = 1725;
  localparam int CALM_TAIL     = 250;   // final offers run with no idling at all
  localparam int DRAIN_EVERY   = 400;
  localparam int SETTLE_CYCLES = 120;
  localparam int IDLE_LIMIT    = 20000; // covers the clearing pass plus slow finds
  localparam int MAX_REPORTS   = 10;
  localparam logic [COST_W-1:0] COST_TOP = '1;

  // one directed offer, with its answer when it is obvious by hand
  typedef struct packed {
    in_t  offer;
    logic given;
    out_t want;
  } plan_t;

  typedef struct packed {
    logic given;
    out_t want;
  } answer_t;

  logic clk_i     = 1'b0;
  logic rst_ni    = 1'b0;
  logic in_valid  = 1'b0;
  logic in_ready;
  in_t  in_data   = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;

  union_find_spanning_selector_unit #(
    .NODES(NODES)
  ) DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Disjoint-set predictor
  // ---------------------------------------------------------------------------
  logic [NODE_W-1:0] up_link     [NODES];
  logic [RANK_W-1:0] tree_rank   [NODES];
  bit                set_powered [NODES];
  logic [SUM_W-1:0]  running_sum;

  int links_taken    = 0;
  int stations_taken = 0;
  int offers_refused = 0;

  function automatic logic [NODE_W-1:0] find_root(input logic [NODE_W-1:0] n);
    logic [NODE_W-1:0] r;
    logic [NODE_W-1:0] next;
    int steps;
    r = n;
    steps = 0;
    while (up_link[r] != r && steps < NODES) begin
      r = up_link[r];
      steps++;
    end
    // compress: every node on the walked path points straight at the root
    steps = 0;
    while (n != r && steps < NODES) begin
      next = up_link[n];
      up_link[n] = r;
      n = next;
      steps++;
    end
    return r;
  endfunction

  function automatic out_t judge_offer(input in_t o);
    out_t res;
    logic [NODE_W-1:0] ra;
    logic [NODE_W-1:0] rb;
    bit merged;
    logic [SUM_W:0] wide;
    res.station_offer = (o.node_a == o.node_b);
    res.accepted = 1'b0;
    // an out-of-range node leaves the store alone (cannot occur at full width)
    if (o.node_a < NODES && o.node_b < NODES) begin
      ra = find_root(o.node_a);
      if (res.station_offer) begin
        if (!set_powered[ra]) begin
          set_powered[ra] = 1'b1;
          res.accepted = 1'b1;
        end
      end else begin
        rb = find_root(o.node_b);
        if (ra != rb && !(set_powered[ra] && set_powered[rb])) begin
          merged = set_powered[ra] | set_powered[rb];
          if (tree_rank[ra] > tree_rank[rb]) begin
            up_link[rb] = ra;
            set_powered[ra] = merged;
          end else begin
            up_link[ra] = rb;
            set_powered[rb] = merged;
            if (tree_rank[ra] == tree_rank[rb] && tree_rank[rb] != RANK_MAX)
              tree_rank[rb] = tree_rank[rb] + RANK_W'(1);
          end
          res.accepted = 1'b1;
        end
      end
      if (res.accepted) begin
        wide = {1'b0, running_sum} + (SUM_W+1)'(o.offer_cost);
        running_sum = (wide > {1'b0, SUM_MAX}) ? SUM_MAX : wide[SUM_W-1:0];
      end
    end
    res.total_cost = running_sum;
    if (!res.accepted) offers_refused++;
    else if (res.station_offer) stations_taken++;
    else links_taken++;
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Transfer monitor and result checker
  // ---------------------------------------------------------------------------
  out_t    owed_results [$];
  answer_t fixed_answers [$];
  plan_t   directed_plan [$];
  int      failures  = 0;
  int      results_seen = 0;
  int      offers_seen  = 0;

  always @(posedge clk_i) begin : monitor
    out_t    want;
    out_t    predicted;
    answer_t tag;
    if (out_valid && out_ready) begin
      if (owed_results.size() == 0) begin
        failures++;
        if (failures <= MAX_REPORTS)
          $display("result %0d arrived with nothing owed: acc=%0b sta=%0b sum=%0d",
                   results_seen, out_data.accepted, out_data.station_offer,
                   out_data.total_cost);
      end else begin
        want = owed_results.pop_front();
        if (out_data.accepted !== want.accepted ||
            out_data.station_offer !== want.station_offer ||
            out_data.total_cost !== want.total_cost) begin
          failures++;
          if (failures <= MAX_REPORTS)
            $display("result %0d: want acc=%0b sta=%0b sum=%0d, got acc=%0b sta=%0b sum=%0d",
                     results_seen, want.accepted, want.station_offer, want.total_cost,
                     out_data.accepted, out_data.station_offer, out_data.total_cost);
        end
      end
      results_seen++;
    end
    if (in_valid && in_ready) begin
      predicted = judge_offer(in_data);
      tag = fixed_answers.pop_front();
      owed_results = {owed_results, (tag.given ? tag.want : predicted)};
      offers_seen++;
    end
  end

  // watchdog: too long without any transfer means the block is stuck
  int quiet_cycles = 0;
  always @(posedge clk_i) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("timeout: no transfer for %0d cycles", IDLE_LIMIT);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: random stall bursts while enabled
  // ---------------------------------------------------------------------------
  bit receiver_stalls = 1'b1;
  bit sender_idles    = 1'b1;

  initial begin
    forever begin
      @(posedge clk_i);
      if (receiver_stalls && $urandom_range(0, 7) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk_i);
      end
      out_ready <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // Sender
  // ---------------------------------------------------------------------------
  task automatic send_offer(input in_t o, input logic given, input out_t want);
    answer_t tag;
    tag.given = given;
    tag.want  = want;
    fixed_answers = {fixed_answers, tag};
    in_data  <= o;
    in_valid <= 1'b1;
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
    if (sender_idles && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk_i);
    end
  endtask

  // hold off until every owed result has been seen
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (owed_results.size() != 0 || fixed_answers.size() != 0) @(posedge clk_i);
  endtask

  task automatic directed_row(input int a, input int b, input logic [COST_W-1:0] cost,
                              input logic given, input logic acc, input logic sta,
                              input logic [SUM_W-1:0] total);
    plan_t p;
    p.offer.node_a = NODE_W'(a);
    p.offer.node_b = NODE_W'(b);
    p.offer.offer_cost = cost;
    p.given = given;
    p.want.accepted = acc;
    p.want.station_offer = sta;
    p.want.total_cost = total;
    directed_plan = {directed_plan, p};
  endtask

  initial begin : main
    in_t              o;
    logic [COST_W-1:0] cost_run;
    logic [63:0]      bumped;
    int               pool_base;
    int               kind;
    int               pick;
    int               node;

    for (int i = 0; i < NODES; i++) begin
      up_link[i]     = NODE_W'(i);
      tree_rank[i]   = '0;
      set_powered[i] = 1'b0;
    end
    running_sum = '0;

    //           a     b     cost      given acc sta total
    directed_row(0,    0,    0,        1,    1,  1,  0);  // first station powers {0}
    directed_row(0,    0,    5,        1,    0,  1,  0);  // already powered
    directed_row(0,    1,    7,        1,    1,  0,  7);  // powered joins unpowered
    directed_row(1,    0,    7,        1,    0,  0,  7);  // same set
    directed_row(2,    3,    10,       1,    1,  0,  17);
    directed_row(2047, 2046, 12,       1,    1,  0,  29); // top node indices
    directed_row(3,    2047, 20,       1,    1,  0,  49); // two unpowered trees
    directed_row(2046, 2046, 25,       1,    1,  1,  74);
    directed_row(1,    2,    30,       1,    0,  0,  74); // both sides powered
    directed_row(2047, 0,    30,       1,    0,  0,  74);
    directed_row(2047, 2047, 31,       1,    0,  1,  74); // powered through its root
    // rank-balanced tree of rank three, then a same-set probe that compresses
    directed_row(4,    5,    100,      0,    0,  0,  0);
    directed_row(6,    7,    100,      0,    0,  0,  0);
    directed_row(4,    6,    110,      0,    0,  0,  0);
    directed_row(5,    7,    110,      0,    0,  0,  0);
    directed_row(8,    9,    120,      0,    0,  0,  0);
    directed_row(10,   11,   120,      0,    0,  0,  0);
    directed_row(8,    10,   130,      0,    0,  0,  0);
    directed_row(4,    8,    130,      0,    0,  0,  0);
    directed_row(9,    5,    140,      0,    0,  0,  0);
    directed_row(12,   12,   150,      0,    0,  0,  0);
    directed_row(12,   4,    150,      0,    0,  0,  0);
    // largest costs, then a cost that breaks the usual ordering
    directed_row(100,  101,  COST_TOP, 0,    0,  0,  0);
    directed_row(1024, 1023, COST_TOP, 0,    0,  0,  0);
    directed_row(102,  103,  1,        0,    0,  0,  0);

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_plan[i])
      send_offer(directed_plan[i].offer, directed_plan[i].given, directed_plan[i].want);
    drain_results();

    // Random part: mostly links inside a small, randomly moved window of nodes so that
    // trees grow deep and same-set offers are common, plus wide links and stations.
    cost_run  = '0;
    pool_base = 0;
    for (int i = 0; i < RANDOM_OFFERS; i++) begin
      if (i == RANDOM_OFFERS - CALM_TAIL) begin
        drain_results();
        sender_idles    = 1'b0;
        receiver_stalls = 1'b0;
      end else if (i % DRAIN_EVERY == DRAIN_EVERY - 1) begin
        drain_results();
      end
      if (i < RANDOM_OFFERS - CALM_TAIL && i % 100 == 0) begin
        sender_idles    = ($urandom_range(0, 3) != 0);
        receiver_stalls = ($urandom_range(0, 3) != 0);
      end
      if (i % 64 == 0) pool_base = $urandom_range(0, NODES - 64);

      kind = $urandom_range(0, 99);
      if (kind < 10) begin
        node = (kind < 5) ? pool_base + $urandom_range(0, 63) : $urandom_range(0, NODES - 1);
        o.node_a = NODE_W'(node);
        o.node_b = NODE_W'(node);
      end else if (kind < 65) begin
        o.node_a = NODE_W'(pool_base + $urandom_range(0, 63));
        o.node_b = NODE_W'(pool_base + $urandom_range(0, 63));
      end else begin
        o.node_a = NODE_W'($urandom_range(0, NODES - 1));
        o.node_b = NODE_W'($urandom_range(0, NODES - 1));
      end

      pick = $urandom_range(0, 99);
      if (pick < 3) begin
        o.offer_cost = COST_W'({$urandom, $urandom});
      end else if (pick < 5) begin
        o.offer_cost = COST_TOP;
      end else begin
        // nondecreasing walk that climbs toward the top of the cost range
        bumped = 64'(cost_run) + (64'($urandom) << $urandom_range(0, 12));
        cost_run = (bumped > 64'(COST_TOP)) ? COST_TOP : bumped[COST_W-1:0];
        o.offer_cost = cost_run;
      end
      send_offer(o, 1'b0, '0);
    end

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    failures += owed_results.size();

    $display("Covered %0d offers (%0d results): %0d links and %0d stations taken, %0d refused.",
             offers_seen, results_seen, links_taken, stations_taken, offers_refused);
    $display("Final running total %0d, %0d failures.", running_sum, failures);
    if (failures == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
